FILE: sv/hsa_pkg.sv
// shared types and constants for the heap sort unit
// no dependencies

package hsa_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int VALUE_W       = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RD_X,
    ST_GET_X,
    ST_CMP_BUILD,
    ST_EX_RD,
    ST_EX_OUT,
    ST_CMP_EXT
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic store_in;
    logic start;
    logic rd_x;
    logic get_x;
    logic cmp;
    logic dec_i;
    logic ex_rd;
    logic ex_out;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic half_zero;
    logic i_one;
    logic sift_done;
    logic n_one;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/hsa_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies

module hsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: sv/hsa_ctrl.sv
// controller state machine for the heap sort unit
// depends on hsa_pkg

module hsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          last,
  output logic          in_ready,
  input  hsa_pkg::sts_t sts,
  output hsa_pkg::cmd_t cmd
);

  hsa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      hsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store_in = 1'b1;
          if (last) begin
            state_next = hsa_pkg::ST_START;
          end
        end
      end
      hsa_pkg::ST_START: begin
        cmd.start  = 1'b1;
        state_next = sts.half_zero ? hsa_pkg::ST_EX_RD : hsa_pkg::ST_RD_X;
      end
      hsa_pkg::ST_RD_X: begin
        cmd.rd_x   = 1'b1;
        state_next = hsa_pkg::ST_GET_X;
      end
      hsa_pkg::ST_GET_X: begin
        cmd.get_x  = 1'b1;
        state_next = hsa_pkg::ST_CMP_BUILD;
      end
      hsa_pkg::ST_CMP_BUILD: begin
        cmd.cmp = 1'b1;
        if (sts.sift_done) begin
          cmd.dec_i  = 1'b1;
          state_next = sts.i_one ? hsa_pkg::ST_EX_RD : hsa_pkg::ST_RD_X;
        end
      end
      hsa_pkg::ST_EX_RD: begin
        // hold until the output register is free next cycle
        if (sts.out_free) begin
          cmd.ex_rd  = 1'b1;
          state_next = hsa_pkg::ST_EX_OUT;
        end
      end
      hsa_pkg::ST_EX_OUT: begin
        cmd.ex_out = 1'b1;
        state_next = sts.n_one ? hsa_pkg::ST_IDLE : hsa_pkg::ST_CMP_EXT;
      end
      hsa_pkg::ST_CMP_EXT: begin
        cmd.cmp = 1'b1;
        if (sts.sift_done) begin
          state_next = hsa_pkg::ST_EX_RD;
        end
      end
      default: begin
        state_next = hsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/hsa_dp.sv
// datapath for the heap sort unit: heap store, counters, sift compare, output register
// depends on hsa_pkg and hsa_ram

module hsa_dp #(
  parameter int DEPTH = hsa_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hsa_pkg::cmd_t                      cmd,
  output hsa_pkg::sts_t                      sts,
  input  logic signed [hsa_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hsa_pkg::VALUE_W-1:0] value_res,
  output logic                               last_res,
  output logic                               overflow
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = AW + 2;
  localparam int VW = hsa_pkg::VALUE_W;

  logic [CW-1:0] count;
  logic          dropped;
  logic [CW-1:0] i;
  logic [CW-1:0] n;
  logic [AW-1:0] j;
  logic signed [VW-1:0] x;

  logic          wen;
  logic [AW-1:0] waddr;
  logic [VW-1:0] wdata;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [VW-1:0] rdata_a, rdata_b;

  logic signed [VW-1:0] left, right, child;
  logic [EW-1:0] l_ext, r_ext, n_ext;
  logic          l_ok, r_ok, swap;
  logic [AW-1:0] c;
  logic [AW-1:0] jn;
  logic [EW-1:0] jn_l, jn_r;
  logic          full;

  assign left  = $signed(rdata_a);
  assign right = $signed(rdata_b);
  assign l_ext = EW'({j, 1'b1});
  assign r_ext = l_ext + EW'(1);
  assign n_ext = EW'(n);
  assign l_ok  = l_ext < n_ext;
  assign r_ok  = r_ext < n_ext;

  // smaller child, right child on a tie
  always_comb begin
    if (r_ok && !(left < right)) begin
      c     = r_ext[AW-1:0];
      child = right;
    end else begin
      c     = l_ext[AW-1:0];
      child = left;
    end
  end

  assign swap = l_ok && (x > child);
  assign full = (count == CW'(DEPTH));

  assign sts.half_zero = (count >> 1) == '0;
  assign sts.i_one     = (i == CW'(1));
  assign sts.sift_done = !swap;
  assign sts.n_one     = (n == CW'(1));
  assign sts.out_free  = !out_valid || out_ready;

  // hole position whose children are fetched this cycle
  always_comb begin
    if (cmd.ex_out) begin
      jn = '0;
    end else if (cmd.cmp) begin
      jn = c;
    end else begin
      jn = j;
    end
  end

  assign jn_l = EW'({jn, 1'b1});
  assign jn_r = jn_l + EW'(1);

  always_comb begin
    if (cmd.ex_rd) begin
      raddr_a = '0;
      raddr_b = AW'(n - CW'(1));
    end else if (cmd.rd_x) begin
      raddr_a = AW'(i - CW'(1));
      raddr_b = jn_r[AW-1:0];
    end else begin
      raddr_a = jn_l[AW-1:0];
      raddr_b = jn_r[AW-1:0];
    end
  end

  always_comb begin
    wen   = 1'b0;
    waddr = j;
    wdata = x;
    if (cmd.store_in) begin
      wen   = !full;
      waddr = AW'(count);
      wdata = value;
    end else if (cmd.cmp) begin
      wen   = 1'b1;
      waddr = j;
      wdata = swap ? child : x;
    end
  end

  hsa_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wen     (wen),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.store_in) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.ex_out && sts.n_one) begin
        count   <= '0;
        dropped <= 1'b0;
      end
      if (cmd.ex_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i <= count >> 1;
      n <= count;
    end
    if (cmd.dec_i) begin
      i <= i - CW'(1);
    end
    if (cmd.rd_x) begin
      j <= AW'(i - CW'(1));
    end
    if (cmd.get_x) begin
      x <= left;
    end
    if (cmd.cmp && swap) begin
      j <= c;
    end
    if (cmd.ex_out) begin
      x         <= right;
      j         <= '0;
      n         <= n - CW'(1);
      value_res <= left;
      last_res  <= sts.n_one;
      overflow  <= dropped;
    end
  end

endmodule

FILE: sv/heap_sort_ascending_unit.sv
// heap sort unit top level: controller plus datapath
// depends on hsa_pkg, hsa_ctrl, hsa_dp

// Takes one signed 32-bit item per cycle into a store of DEPTH entries until an
// item with last set; items past DEPTH are dropped and flag overflow on every
// result of that set. The set is then heapified bottom-up and drained in
// ascending order, last_res marking the final result. All work goes through one
// store with one write and two registered read ports. Each heapify node reads its
// item, captures it and sifts it down a level per compare step, writing the hole
// at each step; each result reads the root and the last item, loads the root for
// output and sifts the last item down from the root. Output stalls hold the drain;
// no new item is taken until the last result of the set has been loaded for output.

module heap_sort_ascending_unit #(
  parameter int DEPTH = hsa_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [hsa_pkg::VALUE_W-1:0] value,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hsa_pkg::VALUE_W-1:0] value_res,
  output logic                               last_res,
  output logic                               overflow
);

  hsa_pkg::cmd_t cmd;
  hsa_pkg::sts_t sts;

  hsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hsa_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_res (value_res),
    .last_res  (last_res),
    .overflow  (overflow)
  );

endmodule
